// File: rtl/oaht_pkg.sv
package oaht_pkg;

  localparam int HASH_BITS       = 32;
  localparam int FILL_LIMIT_BITS = 9;
  localparam int HASH_STEP_BITS  = $clog2(HASH_BITS);

  localparam logic [FILL_LIMIT_BITS-1:0] FILL_LIMIT_RESET = 9'd192;

  typedef enum logic [1:0] {
    REQ_GET = 2'd0,
    REQ_SET = 2'd1,
    REQ_DEL = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_e;

  // per-array write enables of the slot store
  typedef struct packed {
    logic mark;
    logic key;
    logic data;
  } wen_t;

endpackage

// File: rtl/oaht_req_if.sv
interface oaht_req_if
  import oaht_pkg::*;
#(
  parameter int KEY_BITS  = 64,
  parameter int DATA_BITS = 64
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [KEY_BITS-1:0]  key;
  logic [HASH_BITS-1:0] hash;
  logic [DATA_BITS-1:0] data_in;

  modport source (output valid, req_type, key, hash, data_in, input ready);
  modport sink   (input valid, req_type, key, hash, data_in, output ready);
endinterface

// File: rtl/oaht_rsp_if.sv
interface oaht_rsp_if #(
  parameter int DATA_BITS = 64
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic                 new_key;
  logic [DATA_BITS-1:0] data_out;

  modport source (output valid, status, new_key, data_out, input ready);
  modport sink   (input valid, status, new_key, data_out, output ready);
endinterface

// File: rtl/oaht_cfg_if.sv
interface oaht_cfg_if
  import oaht_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [FILL_LIMIT_BITS-1:0] fill_limit;

  modport source (output valid, fill_limit, input ready);
  modport sink   (input valid, fill_limit, output ready);
endinterface

// File: rtl/oaht_store.sv
module oaht_store
  import oaht_pkg::*;
#(
  parameter int SLOTS     = 256,
  parameter int KEY_BITS  = 64,
  parameter int DATA_BITS = 64,
  parameter int IW        = 8
) (
  input  logic                 clk_i,
  input  wen_t                 wr_en_i,
  input  logic [IW-1:0]        wr_addr_i,
  input  logic [1:0]           wr_mark_i,
  input  logic [KEY_BITS-1:0]  wr_key_i,
  input  logic [DATA_BITS-1:0] wr_data_i,
  input  logic [IW-1:0]        rd_addr_i,
  output logic [1:0]           rd_mark_o,
  output logic [KEY_BITS-1:0]  rd_key_o,
  output logic [DATA_BITS-1:0] rd_data_o
);

  logic [1:0]           mark_mem [SLOTS];
  logic [KEY_BITS-1:0]  key_mem  [SLOTS];
  logic [DATA_BITS-1:0] data_mem [SLOTS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i.mark) begin
      mark_mem[wr_addr_i] <= wr_mark_i;
    end
    if (wr_en_i.key) begin
      key_mem[wr_addr_i] <= wr_key_i;
    end
    if (wr_en_i.data) begin
      data_mem[wr_addr_i] <= wr_data_i;
    end
    rd_mark_o <= mark_mem[rd_addr_i];
    rd_key_o  <= key_mem[rd_addr_i];
    rd_data_o <= data_mem[rd_addr_i];
  end

endmodule

// File: rtl/open_addressing_hash_table.sv
// Open-addressing hash table, linear probing with tombstones.
// req_i takes one get/set/delete request (key, precomputed hash, value);
// rsp_o returns exactly one response per request (status, new_key,
// data_out). cfg_i writes fill_limit and is always ready; write it only
// while no request is in flight.
// One request at a time: req_i.ready is high only while the sequencer is
// idle. Slots are probed one per cycle through the slot store's registered
// read port, at most SLOTS per request. When SLOTS is not a power of two,
// the start slot comes from a reciprocal multiply of the hash. Get or
// delete on an empty table, and an unused request type, skip the probe
// and go straight to the response.
// The response sits in an output register; the next request can be
// accepted while it waits, and its own response then holds in the
// sequencer until rsp_o is taken, so a stalled receiver stalls req_i.
// After reset the block sweeps the slot marks to empty, one slot a cycle,
// through all SLOTS slots with req_i.ready low; fill_limit resets to 192.
module open_addressing_hash_table
  import oaht_pkg::*;
#(
  parameter int SLOTS     = 256,
  parameter int KEY_BITS  = 64,
  parameter int DATA_BITS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  oaht_req_if.sink   req_i,
  oaht_rsp_if.source rsp_o,
  oaht_cfg_if.sink   cfg_i
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int LW = (CW > FILL_LIMIT_BITS) ? CW : FILL_LIMIT_BITS;
  localparam bit POW2 = ((SLOTS & (SLOTS - 1)) == 0);
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);
  localparam logic [HASH_BITS-1:0] SLOTS_H = HASH_BITS'(SLOTS);
  localparam logic [HASH_BITS-1:0] RECIP = HASH_BITS'((64'd1 << HASH_BITS) / SLOTS);
  localparam logic [1:0] STEP_QUOT = 2'd0;
  localparam logic [1:0] STEP_REM  = 2'd1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_ISSUE,
    S_CHECK,
    S_RESP
  } state_e;

  state_e state_q, state_d;

  logic [IW-1:0]              idx_q, idx_d;
  logic [IW-1:0]              cnt_q, cnt_d;
  logic [1:0]                 step_q, step_d;
  logic [HASH_BITS-1:0]       hash_q, hash_d;
  logic [HASH_BITS-1:0]       quot_q, quot_d;
  logic [1:0]                 req_q, req_d;
  logic [KEY_BITS-1:0]        key_q, key_d;
  logic [DATA_BITS-1:0]       din_q, din_d;
  logic                       tomb_seen_q, tomb_seen_d;
  logic [IW-1:0]              tomb_idx_q, tomb_idx_d;
  logic [CW-1:0]              filled_q, filled_d;
  logic [FILL_LIMIT_BITS-1:0] limit_q, limit_d;
  logic [1:0]                 pend_status_q, pend_status_d;
  logic                       pend_new_q, pend_new_d;
  logic [DATA_BITS-1:0]       pend_dout_q, pend_dout_d;
  logic                       out_valid_q, out_valid_d;
  logic [1:0]                 out_status_q, out_status_d;
  logic                       out_new_q, out_new_d;
  logic [DATA_BITS-1:0]       out_dout_q, out_dout_d;

  wen_t                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic [1:0]           wr_mark;
  logic [KEY_BITS-1:0]  wr_key;
  logic [DATA_BITS-1:0] wr_data;
  logic [IW-1:0]        rd_addr;
  logic [1:0]           rd_mark;
  logic [KEY_BITS-1:0]  rd_key;
  logic [DATA_BITS-1:0] rd_data;

  logic [IW-1:0]          idx_inc;
  logic [2*HASH_BITS-1:0] prod;
  logic                   req_acc;
  logic                   is_empty, is_hit, is_tomb;
  logic                   fin, hit, have_place, place_empty;
  logic [IW-1:0]          place;
  logic                   over_limit;

  oaht_store #(
    .SLOTS     (SLOTS),
    .KEY_BITS  (KEY_BITS),
    .DATA_BITS (DATA_BITS),
    .IW        (IW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_mark_i (wr_mark),
    .wr_key_i  (wr_key),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_mark_o (rd_mark),
    .rd_key_o  (rd_key),
    .rd_data_o (rd_data)
  );

  assign req_i.ready    = (state_q == S_IDLE);
  assign req_acc        = req_i.valid && req_i.ready;
  assign cfg_i.ready    = 1'b1;
  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.status   = out_status_q;
  assign rsp_o.new_key  = out_new_q;
  assign rsp_o.data_out = out_dout_q;

  assign idx_inc = (idx_q == LAST_SLOT) ? '0 : idx_q + 1'b1;
  assign prod    = (2*HASH_BITS)'(hash_q) * (2*HASH_BITS)'(RECIP);

  assign is_empty   = (rd_mark == MARK_EMPTY);
  assign is_hit     = (rd_mark == MARK_LIVE) && (rd_key == key_q);
  assign is_tomb    = !is_empty && (rd_mark != MARK_LIVE);
  assign over_limit = (LW'(filled_q) >= LW'(limit_q));

  // probe outcome of the slot read back this cycle
  always_comb begin
    fin         = 1'b0;
    hit         = 1'b0;
    have_place  = 1'b0;
    place_empty = 1'b0;
    place       = idx_q;
    if (is_hit) begin
      fin = 1'b1;
      hit = 1'b1;
    end else if (is_empty) begin
      fin         = 1'b1;
      have_place  = 1'b1;
      place_empty = !tomb_seen_q;
      place       = tomb_seen_q ? tomb_idx_q : idx_q;
    end else if (cnt_q == LAST_SLOT) begin
      // full pass without key or empty slot
      fin        = 1'b1;
      have_place = tomb_seen_q || is_tomb;
      place      = tomb_seen_q ? tomb_idx_q : idx_q;
    end
  end

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    cnt_d         = cnt_q;
    step_d        = step_q;
    hash_d        = hash_q;
    quot_d        = quot_q;
    req_d         = req_q;
    key_d         = key_q;
    din_d         = din_q;
    tomb_seen_d   = tomb_seen_q;
    tomb_idx_d    = tomb_idx_q;
    filled_d      = filled_q;
    limit_d       = limit_q;
    pend_status_d = pend_status_q;
    pend_new_d    = pend_new_q;
    pend_dout_d   = pend_dout_q;
    out_valid_d   = out_valid_q;
    out_status_d  = out_status_q;
    out_new_d     = out_new_q;
    out_dout_d    = out_dout_q;
    wr_en         = '0;
    wr_addr       = idx_q;
    wr_mark       = MARK_EMPTY;
    wr_key        = key_q;
    wr_data       = din_q;
    rd_addr       = idx_q;

    if (cfg_i.valid) begin
      limit_d = cfg_i.fill_limit;
    end
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        wr_en.mark = 1'b1;
        idx_d      = idx_inc;
        if (idx_q == LAST_SLOT) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_acc) begin
          req_d         = req_i.req_type;
          key_d         = req_i.key;
          hash_d        = req_i.hash;
          din_d         = req_i.data_in;
          cnt_d         = '0;
          step_d        = '0;
          tomb_seen_d   = 1'b0;
          pend_status_d = ST_NOTFOUND;
          pend_new_d    = 1'b0;
          pend_dout_d   = '0;
          idx_d         = POW2 ? req_i.hash[IW-1:0] : '0;
          if ((req_i.req_type != REQ_GET && req_i.req_type != REQ_SET &&
               req_i.req_type != REQ_DEL) ||
              (req_i.req_type != REQ_SET && filled_q == '0)) begin
            state_d = S_RESP;
          end else begin
            state_d = POW2 ? S_ISSUE : S_MOD;
          end
        end
      end
      S_MOD: begin
        // quotient estimate from the reciprocal is low by at most one,
        // so one compare and subtract finishes the remainder
        step_d = step_q + 1'b1;
        unique case (step_q)
          STEP_QUOT: begin
            quot_d = prod[2*HASH_BITS-1:HASH_BITS];
          end
          STEP_REM: begin
            hash_d = hash_q - quot_q * SLOTS_H;
          end
          default: begin
            idx_d   = (hash_q >= SLOTS_H) ? IW'(hash_q - SLOTS_H) : hash_q[IW-1:0];
            state_d = S_ISSUE;
          end
        endcase
      end
      S_ISSUE: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        // next slot is read speculatively; no writes happen mid-probe
        rd_addr = idx_inc;
        if (fin) begin
          state_d = S_RESP;
          unique case (req_q)
            REQ_GET: begin
              if (hit) begin
                pend_status_d = ST_OK;
                pend_dout_d   = rd_data;
              end
            end
            REQ_DEL: begin
              if (hit) begin
                pend_status_d = ST_OK;
                wr_en.mark    = 1'b1;
                wr_addr       = idx_q;
                wr_mark       = MARK_TOMB;
              end
            end
            REQ_SET: begin
              if (hit) begin
                pend_status_d = ST_OK;
                wr_en.data    = 1'b1;
                wr_addr       = idx_q;
              end else if (!have_place || (place_empty && over_limit)) begin
                pend_status_d = ST_FULL;
              end else begin
                pend_status_d = ST_OK;
                pend_new_d    = 1'b1;
                wr_en         = '{mark: 1'b1, key: 1'b1, data: 1'b1};
                wr_addr       = place;
                wr_mark       = MARK_LIVE;
                if (place_empty) begin
                  filled_d = filled_q + 1'b1;
                end
              end
            end
            default: begin
              pend_status_d = ST_NOTFOUND;
            end
          endcase
        end else begin
          if (is_tomb && !tomb_seen_q) begin
            tomb_seen_d = 1'b1;
            tomb_idx_d  = idx_q;
          end
          idx_d = idx_inc;
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = pend_status_q;
          out_new_d    = pend_new_q;
          out_dout_d   = pend_dout_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      filled_q    <= '0;
      limit_q     <= FILL_LIMIT_RESET;
      out_valid_q <= 1'b0;
      tomb_seen_q <= 1'b0;
      cnt_q       <= '0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      filled_q    <= filled_d;
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
      tomb_seen_q <= tomb_seen_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q        <= hash_d;
    quot_q        <= quot_d;
    req_q         <= req_d;
    key_q         <= key_d;
    din_q         <= din_d;
    tomb_idx_q    <= tomb_idx_d;
    pend_status_q <= pend_status_d;
    pend_new_q    <= pend_new_d;
    pend_dout_q   <= pend_dout_d;
    out_status_q  <= out_status_d;
    out_new_q     <= out_new_d;
    out_dout_q    <= out_dout_d;
  end

endmodule
